### design/bemt_pkg.sv
`timescale 1ns / 1ps

package bemt_pkg;

    // Field widths
    localparam int MAG_W   = 24;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int SQ_SHR  = 12;
    localparam int SQ_W    = PROD_W - SQ_SHR;
    localparam int E_W     = 42;
    localparam int TS_W    = 32;
    localparam int RATIO_W = 16;
    localparam int FBIN_W  = 9;
    localparam int EBIN_W  = 10;
    localparam int HOLD_W  = 16;
    localparam int RHS_W   = RATIO_W + E_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 42;

    // Fixed-point constants, Q.16
    localparam logic [E_W-1:0] E_MAX      = {E_W{1'b1}};
    localparam logic [E_W-1:0] OFFSET_Q16 = E_W'(655);
    localparam logic [E_W-1:0] FLOOR_Q16  = E_W'(655360);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_RATIO      = 3'd1,
        CFG_ABS_THR    = 3'd2,
        CFG_MIN_ENERGY = 3'd3,
        CFG_MAX_ENERGY = 3'd4,
        CFG_FIRST_BIN  = 3'd5,
        CFG_END_BIN    = 3'd6,
        CFG_HOLDOFF    = 3'd7
    } t_cfg_idx;

    // Closed frame from the band accumulator
    typedef struct packed {
        logic            vld;
        logic [E_W-1:0]  energy;
        logic [TS_W-1:0] now_ms;
    } t_frame;

    // Link passed from a sort cell to its right neighbor
    typedef struct packed {
        logic [E_W-1:0] val;
        logic           ins;
    } t_fwd;

    // Link passed from a sort cell to its left neighbor
    typedef struct packed {
        logic [E_W-1:0] val;
        logic           gt_new;
    } t_bwd;

endpackage

### design/band_energy_median_trigger_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: magnitude, now_ms; tlast: last_bin
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: frame_energy, baseline,
//                                               indicator_level; tuser: event_res
// cfg       in   i_cfg_wr_en                    i_cfg_index, i_cfg_data
//
// One bin is taken every cycle unless stalled; frames may be as short as a single bin.
// A frame's result passes the square, closed-frame, decision and output registers.
// The sorted history updates once per frame, so back-to-back frame ends keep pace.
// Synchronous active-low reset clears the history to zero and loads register defaults.
// s_axis_tready drops only while a finished frame waits behind an untaken result.

module band_energy_median_trigger_unit import bemt_pkg::*; #(
    parameter int HISTORY_DEPTH = 16,
    parameter int FFT_POINTS    = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // bins in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [55:0]           s_axis_tdata,   // [23:0] magnitude, [55:24] now_ms
    input  logic                  s_axis_tlast,
    // frame results out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [87:0]           m_axis_tdata,   // [41:0] frame_energy, [83:42] baseline,
                                                  // [84] indicator_level, [87:85] zero
    output logic                  m_axis_tuser,   // [0] event_res
    // configuration writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic               r_enable;
    logic [RATIO_W-1:0] r_ratio;
    logic [E_W-1:0]     r_abs_thr;
    logic [E_W-1:0]     r_min_energy;
    logic [E_W-1:0]     r_max_energy;
    logic [FBIN_W-1:0]  r_first_bin;
    logic [EBIN_W-1:0]  r_end_bin;
    logic [HOLD_W-1:0]  r_holdoff;

    logic               w_adv;
    t_frame             w_frame;
    logic [E_W-1:0]     w_base;
    logic [E_W:0]       w_base_off;
    logic [RHS_W-1:0]   w_rhs;

    // Decision stage
    logic               r_s3_vld;
    logic [E_W-1:0]     r_s3_energy;
    logic [E_W-1:0]     r_s3_base;
    logic [RHS_W-1:0]   r_s3_rhs;
    logic [TS_W-1:0]    r_s3_now;

    logic [RHS_W-1:0]   w_lhs;
    logic [TS_W-1:0]    w_elapsed;
    logic               w_hit;

    // Trigger state and output register
    logic [TS_W-1:0]    r_last_trig;
    logic               r_ind;
    logic               r_out_vld;
    logic               r_out_event;
    logic [E_W-1:0]     r_out_energy;
    logic [E_W-1:0]     r_out_base;
    logic               r_out_ind;

    // Stall only when a frame result would land on an untaken one
    assign w_adv         = !(r_s3_vld && r_out_vld && !m_axis_tready);
    assign s_axis_tready = w_adv;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_ratio      <= RATIO_W'(768);
            r_abs_thr    <= E_MAX;
            r_min_energy <= '0;
            r_max_energy <= E_MAX;
            r_first_bin  <= FBIN_W'(1);
            r_end_bin    <= EBIN_W'(50);
            r_holdoff    <= HOLD_W'(600);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_RATIO:      r_ratio      <= i_cfg_data[RATIO_W-1:0];
                CFG_ABS_THR:    r_abs_thr    <= i_cfg_data[E_W-1:0];
                CFG_MIN_ENERGY: r_min_energy <= i_cfg_data[E_W-1:0];
                CFG_MAX_ENERGY: r_max_energy <= i_cfg_data[E_W-1:0];
                CFG_FIRST_BIN:  r_first_bin  <= i_cfg_data[FBIN_W-1:0];
                CFG_END_BIN:    r_end_bin    <= i_cfg_data[EBIN_W-1:0];
                CFG_HOLDOFF:    r_holdoff    <= i_cfg_data[HOLD_W-1:0];
                default:        r_enable     <= r_enable;
            endcase
        end
    end

    bemt_band_acc #(
        .FFT_POINTS (FFT_POINTS)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (s_axis_tvalid),
        .i_mag       (s_axis_tdata[MAG_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_now       (s_axis_tdata[MAG_W+TS_W-1:MAG_W]),
        .i_first_bin (r_first_bin),
        .i_end_bin   (r_end_bin),
        .o_frame     (w_frame)
    );

    bemt_sort_chain #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_adv && w_frame.vld),
        .i_new   (w_frame.energy),
        .o_base  (w_base)
    );

    // Ratio bound: ratio * (baseline + 0.01)
    assign w_base_off = {1'b0, w_base} + {1'b0, OFFSET_Q16};
    assign w_rhs      = RHS_W'(r_ratio) * RHS_W'(w_base_off);

    // Load the decision stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s3_vld <= w_frame.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_frame.vld) begin
            r_s3_energy <= w_frame.energy;
            r_s3_base   <= w_base;
            r_s3_rhs    <= w_rhs;
            r_s3_now    <= w_frame.now_ms;
        end
    end

    // Trigger test
    always_comb begin
        w_lhs     = RHS_W'({r_s3_energy, 8'b0});
        w_elapsed = r_s3_now - r_last_trig;
        w_hit     = ((w_lhs >= r_s3_rhs) || (r_s3_energy >= r_abs_thr)) &&
                    (r_s3_energy >= r_min_energy) &&
                    (r_s3_energy <= r_max_energy) &&
                    (r_s3_energy > FLOOR_Q16) &&
                    r_enable &&
                    (w_elapsed >= TS_W'(r_holdoff));
    end

    // Debounce time, indicator and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_trig <= '0;
            r_ind       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else if (w_adv && r_s3_vld) begin
            r_out_vld    <= 1'b1;
            r_out_event  <= w_hit;
            r_out_energy <= r_s3_energy;
            r_out_base   <= r_s3_base;
            r_out_ind    <= r_ind ^ w_hit;
            if (w_hit) begin
                r_last_trig <= r_s3_now;
                r_ind       <= ~r_ind;
            end
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_event;
    assign m_axis_tdata  = {3'b000, r_out_ind, r_out_base, r_out_energy};

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_vld && r_s3_vld))
        else $error("input stalled without a pending result");

    a_event_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s3_vld && w_hit) |=> (r_ind != $past(r_ind)))
        else $error("indicator did not toggle on event");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s3_vld) |=> (r_out_vld && (m_axis_tdata[84] == r_ind)))
        else $error("frame result not presented");

endmodule

### design/bemt_band_acc.sv
`timescale 1ns / 1ps

module bemt_band_acc import bemt_pkg::*; #(
    parameter int FFT_POINTS = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic              i_last,
    input  logic [TS_W-1:0]   i_now,
    input  logic [FBIN_W-1:0] i_first_bin,
    input  logic [EBIN_W-1:0] i_end_bin,
    output t_frame            o_frame
);

    localparam int CNT_W = $clog2(FFT_POINTS + 1);
    localparam int CMP_W = (CNT_W > EBIN_W) ? CNT_W : EBIN_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FFT_POINTS);

    logic [CNT_W-1:0]  r_cnt;
    logic [CMP_W-1:0]  w_idx;
    logic              w_in_band;
    logic [PROD_W-1:0] w_prod;

    logic              r_p1_vld;
    logic              r_p1_last;
    logic              r_p1_band;
    logic [SQ_W-1:0]   r_p1_sq;
    logic [TS_W-1:0]   r_p1_now;

    logic [E_W-1:0]    r_sum;
    logic [E_W:0]      w_sum_add;
    logic [E_W-1:0]    w_sum_nxt;

    logic              r_frm_vld;
    logic [E_W-1:0]    r_frm_energy;
    logic [TS_W-1:0]   r_frm_now;

    // Band test on the current bin index
    assign w_idx     = CMP_W'(r_cnt);
    assign w_in_band = (r_cnt < CNT_LIMIT) &&
                       (w_idx >= CMP_W'(i_first_bin)) &&
                       (w_idx < CMP_W'(i_end_bin));
    assign w_prod    = i_mag * i_mag;

    // Saturating accumulate of the registered square
    always_comb begin
        w_sum_add = {1'b0, r_sum} + (E_W + 1)'(r_p1_sq);
        if (!r_p1_band) begin
            w_sum_nxt = r_sum;
        end else if (w_sum_add[E_W]) begin
            w_sum_nxt = E_MAX;
        end else begin
            w_sum_nxt = w_sum_add[E_W-1:0];
        end
    end

    // Control: bin counter, running sum, stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sum     <= '0;
            r_p1_vld  <= 1'b0;
            r_frm_vld <= 1'b0;
        end else if (i_adv) begin
            r_p1_vld  <= i_valid;
            r_frm_vld <= r_p1_vld && r_p1_last;
            if (i_valid) begin
                if (i_last) begin
                    r_cnt <= '0;
                end else if (r_cnt < CNT_LIMIT) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (r_p1_vld) begin
                r_sum <= r_p1_last ? '0 : w_sum_nxt;
            end
        end
    end

    // Payload: square stage and closed frame
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_valid) begin
                r_p1_last <= i_last;
                r_p1_band <= w_in_band;
                r_p1_sq   <= w_prod[PROD_W-1:SQ_SHR];
                r_p1_now  <= i_now;
            end
            if (r_p1_vld && r_p1_last) begin
                r_frm_energy <= w_sum_nxt;
                r_frm_now    <= r_p1_now;
            end
        end
    end

    assign o_frame.vld    = r_frm_vld;
    assign o_frame.energy = r_frm_energy;
    assign o_frame.now_ms = r_frm_now;

endmodule

### design/bemt_cell.sv
`timescale 1ns / 1ps

module bemt_cell import bemt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_upd,
    input  logic [E_W-1:0] i_new,
    input  logic [E_W-1:0] i_old,
    input  t_fwd           i_left,
    input  t_bwd           i_right,
    output t_fwd           o_right,
    output t_bwd           o_left,
    output logic [E_W-1:0] o_val
);

    logic [E_W-1:0] r_val;
    logic           w_ge_old;
    logic           w_gt_new;
    t_fwd           w_fwd;
    logic [E_W-1:0] n_val;

    // Position relative to the removed entry and to the new entry
    assign w_ge_old = (r_val >= i_old);
    assign w_gt_new = (r_val > i_new);

    // Value at this place once the oldest entry is gone and the new one is in
    always_comb begin
        w_fwd.val = w_ge_old ? i_right.val : r_val;
        w_fwd.ins = w_ge_old ? i_right.gt_new : w_gt_new;
        if (i_left.ins) begin
            n_val = i_left.val;
        end else if (w_fwd.ins) begin
            n_val = i_new;
        end else begin
            n_val = w_fwd.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_upd) begin
            r_val <= n_val;
        end
    end

    assign o_right       = w_fwd;
    assign o_left.val    = r_val;
    assign o_left.gt_new = w_gt_new;
    assign o_val         = r_val;

endmodule

### design/bemt_sort_chain.sv
`timescale 1ns / 1ps

module bemt_sort_chain import bemt_pkg::*; #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_upd,
    input  logic [E_W-1:0] i_new,
    output logic [E_W-1:0] o_base
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int MID   = HISTORY_DEPTH / 2;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    // Ring of past energies in arrival order
    logic [E_W-1:0]           r_ring [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_ring_vld;
    logic [PTR_W-1:0]         r_ptr;
    logic [PTR_W-1:0]         w_ptr_nxt;
    logic [E_W-1:0]           r_old;

    t_fwd           w_fwd [HISTORY_DEPTH+1];
    t_bwd           w_bwd [HISTORY_DEPTH+1];
    logic [E_W-1:0] w_val [HISTORY_DEPTH];

    assign w_ptr_nxt = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);

    // Chain ends: nothing enters from the left, the right end always takes the insert
    assign w_fwd[0].val                = '0;
    assign w_fwd[0].ins                = 1'b0;
    assign w_bwd[HISTORY_DEPTH].val    = '0;
    assign w_bwd[HISTORY_DEPTH].gt_new = 1'b1;

    // Sorted row of cells, ascending from cell 0
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        bemt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_upd   (i_upd),
            .i_new   (i_new),
            .i_old   (r_old),
            .i_left  (w_fwd[k]),
            .i_right (w_bwd[k+1]),
            .o_right (w_fwd[k+1]),
            .o_left  (w_bwd[k]),
            .o_val   (w_val[k])
        );
    end

    assign o_base = w_val[MID];

    // Pointer, valid bits and prefetch of the next entry to retire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_ring_vld <= '0;
            r_old      <= '0;
        end else if (i_upd) begin
            r_ptr             <= w_ptr_nxt;
            r_ring_vld[r_ptr] <= 1'b1;
            r_old             <= r_ring_vld[w_ptr_nxt] ? r_ring[w_ptr_nxt] : '0;
        end
    end

    // Write the new energy over the oldest one
    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_ring[r_ptr] <= i_new;
        end
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("history pointer out of range");

    a_ring_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd |=> r_ring_vld[$past(r_ptr)])
        else $error("written ring entry not marked valid");

    for (genvar k = 0; k < HISTORY_DEPTH - 1; k++) begin : g_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_val[k] <= w_val[k+1])
            else $error("sort chain out of order");
    end

endmodule

### bench/band_energy_median_trigger_unit_tb.sv
`timescale 1ns / 1ps

module band_energy_median_trigger_unit_tb;
    import bemt_pkg::*;

    localparam int HIST        = 16;
    localparam int FFT_N       = 512;
    localparam int RAND_BINS   = 150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic           ev;
        logic [E_W-1:0] energy;
        logic [E_W-1:0] base;
        logic           ind;
    } t_frame_result;

    typedef enum logic { ROW_BINS, ROW_REG } t_row_kind;

    typedef struct {
        t_row_kind       kind;
        t_cfg_idx        reg_idx;
        logic [E_W-1:0]  reg_val;
        logic [MAG_W-1:0] mag;
        int              count;
        bit              last;
        logic [TS_W-1:0] now;
        bit              typed;
        t_frame_result   want;
    } t_plan_row;

    // DUT ports, all inputs known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata = '0;   // [23:0] magnitude, [55:24] now_ms
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [87:0]           m_axis_tdata;        // [41:0] frame_energy, [83:42] baseline,
                                                // [84] indicator_level
    logic                  m_axis_tuser;        // [0] event_res
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    band_energy_median_trigger_unit #(
        .HISTORY_DEPTH(HIST),
        .FFT_POINTS   (FFT_N)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Detector model: registers
    logic                 en_r    = 1'b0;
    logic [RATIO_W-1:0]   ratio_r = 16'd768;
    logic [E_W-1:0]       abs_r   = E_MAX;
    logic [E_W-1:0]       min_r   = '0;
    logic [E_W-1:0]       max_r   = E_MAX;
    logic [FBIN_W-1:0]    fbin_r  = 9'd1;
    logic [EBIN_W-1:0]    ebin_r  = 10'd50;
    logic [HOLD_W-1:0]    hold_r  = 16'd600;

    // Detector model: state
    logic [E_W-1:0]       acc_sum     = '0;
    logic [EBIN_W-1:0]    bin_idx     = '0;
    logic [E_W-1:0]       ring [HIST];
    int                   ring_wr     = 0;
    logic [TS_W-1:0]      last_hit_ms = '0;
    logic                 ind_r       = 1'b0;

    t_frame_result        pending_frames [$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    bit                   src_idle       = 1'b1;
    bit                   snk_idle       = 1'b1;
    bit                   hold_req       = 1'b0;

    initial begin
        for (int i = 0; i < HIST; i++) ring[i] = '0;
    end

    // Accumulate one bin; at the frame end compute energy, baseline and decision
    function automatic bit band_frame_step(input logic [MAG_W-1:0] mag, input logic last,
                                           input logic [TS_W-1:0] now,
                                           output t_frame_result res);
        logic [63:0]     sq;
        logic [63:0]     sum;
        logic [63:0]     lhs;
        logic [63:0]     rhs;
        logic [E_W-1:0]  energy;
        logic [E_W-1:0]  base;
        logic [E_W-1:0]  srt [HIST];
        logic [E_W-1:0]  v;
        logic [TS_W-1:0] elapsed;
        int              j;
        bit              hit;
        res = '0;
        if (bin_idx < FFT_N && bin_idx >= fbin_r && bin_idx < ebin_r) begin
            sq = (64'(mag) * 64'(mag)) >> SQ_SHR;
            sum = 64'(acc_sum) + sq;
            acc_sum = (sum > 64'(E_MAX)) ? E_MAX : sum[E_W-1:0];
        end
        if (bin_idx < FFT_N) bin_idx++;
        if (!last) return 1'b0;

        energy = acc_sum;
        acc_sum = '0;
        bin_idx = '0;

        // Upper median of the history, before the new energy goes in
        for (int i = 0; i < HIST; i++) begin
            v = ring[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        base = srt[HIST/2];
        ring[ring_wr] = energy;
        ring_wr = (ring_wr + 1) % HIST;

        lhs = 64'(energy) << 8;
        rhs = 64'(ratio_r) * (64'(base) + 64'(OFFSET_Q16));
        elapsed = now - last_hit_ms;
        hit = (lhs >= rhs || energy >= abs_r) && energy >= min_r && energy <= max_r
              && energy > FLOOR_Q16 && en_r && (elapsed >= TS_W'(hold_r));
        if (hit) begin
            last_hit_ms = now;
            ind_r = ~ind_r;
        end
        res = '{ev: hit, energy: energy, base: base, ind: ind_r};
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one bin, hold it until taken, then queue what the frame should give
    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last,
                            input logic [TS_W-1:0] now, input bit typed,
                            input t_frame_result want);
        int            gap;
        t_frame_result res;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, mag};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (band_frame_step(mag, last, now, res))
            pending_frames.push_back(typed ? want : res);
    endtask

    // Drop valid, drain all results, then give the pipeline time to empty
    task automatic settle();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [E_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ENABLE:     en_r    = val[0];
            CFG_RATIO:      ratio_r = val[RATIO_W-1:0];
            CFG_ABS_THR:    abs_r   = val;
            CFG_MIN_ENERGY: min_r   = val;
            CFG_MAX_ENERGY: max_r   = val;
            CFG_FIRST_BIN:  fbin_r  = val[FBIN_W-1:0];
            CFG_END_BIN:    ebin_r  = val[EBIN_W-1:0];
            CFG_HOLDOFF:    hold_r  = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_plan_row reg_row(input t_cfg_idx idx, input logic [E_W-1:0] val);
        t_plan_row r;
        r = '{kind: ROW_REG, reg_idx: CFG_ENABLE, default: '0};
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_plan_row bins_row(input logic [MAG_W-1:0] mag, input int count,
                                           input bit last, input logic [TS_W-1:0] now);
        t_plan_row r;
        r = '{kind: ROW_BINS, reg_idx: CFG_ENABLE, default: '0};
        r.kind  = ROW_BINS;
        r.reg_idx = CFG_ENABLE;
        r.mag   = mag;
        r.count = count;
        r.last  = last;
        r.now   = now;
        return r;
    endfunction

    function automatic t_plan_row bins_typed(input logic [MAG_W-1:0] mag, input int count,
                                             input logic [TS_W-1:0] now,
                                             input t_frame_result want);
        t_plan_row r;
        r = bins_row(mag, count, 1'b1, now);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [E_W-1:0] rand_energy();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[E_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] rand_mag(input int style);
        case (style)
            0:       return MAG_W'($urandom_range(0, 255));
            1:       return MAG_W'($urandom_range(0, 16'h3FFF));
            2:       return MAG_W'($urandom_range(0, 18'h3FFFF));
            default: return MAG_W'($urandom);
        endcase
    endfunction

    // Sink side: random stalls, plus one long hold-off when asked
    initial begin : result_sink
        int g;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end
            g = snk_idle ? $urandom_range(0, 8) : 0;
            if (g > 0) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end
            @(negedge i_clk) m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Compare each result beat with the oldest expected frame
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_frames.size() == 0) begin
                flag_mismatch("unexpected frame result", 64'(m_axis_tdata[41:0]), 64'd0);
            end else begin
                want = pending_frames.pop_front();
                if (m_axis_tuser !== want.ev)
                    flag_mismatch("event_res", 64'(m_axis_tuser), 64'(want.ev));
                if (m_axis_tdata[41:0] !== want.energy)
                    flag_mismatch("frame_energy", 64'(m_axis_tdata[41:0]), 64'(want.energy));
                if (m_axis_tdata[83:42] !== want.base)
                    flag_mismatch("baseline", 64'(m_axis_tdata[83:42]), 64'(want.base));
                if (m_axis_tdata[84] !== want.ind)
                    flag_mismatch("indicator_level", 64'(m_axis_tdata[84]), 64'(want.ind));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("band_energy_median_trigger_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row        plan [$];
        bit               prev_bins;
        bit               lst;
        int               rand_bins;
        int               phase;
        int               nframes;
        int               len;
        int               style;
        logic [TS_W-1:0]  now;
        logic [E_W-1:0]   val;

        // Disabled, then debounce right after reset, then saturation
        plan.push_back(bins_typed(24'hFFFFFF, 1, 32'd0, '{1'b0, 42'd0, 42'd0, 1'b0}));
        plan.push_back(bins_row(24'h000000, 1, 1'b0, 32'd0));
        plan.push_back(bins_typed(24'hFFFFFF, 1, 32'd5,
                                  '{1'b0, 42'hFFFFFE000, 42'd0, 1'b0}));
        plan.push_back(reg_row(CFG_ENABLE, 42'd1));
        plan.push_back(bins_typed(24'hFFFFFF, 3, 32'd599,
                                  '{1'b0, 42'h1FFFFFC000, 42'd0, 1'b0}));
        plan.push_back(bins_row(24'hFFFFFF, 3, 1'b1, 32'd600));
        plan.push_back(reg_row(CFG_HOLDOFF, 42'd0));
        plan.push_back(reg_row(CFG_FIRST_BIN, 42'd0));
        plan.push_back(reg_row(CFG_END_BIN, 42'd512));
        plan.push_back(bins_typed(24'hFFFFFF, 66, 32'd1000, '{1'b1, E_MAX, 42'd0, 1'b0}));
        // Long frame: counter stops at the FFT size
        plan.push_back(bins_row(24'h004000, 530, 1'b1, 32'd1001));
        // Empty band, and the widest inverted band
        plan.push_back(reg_row(CFG_FIRST_BIN, 42'd10));
        plan.push_back(reg_row(CFG_END_BIN, 42'd10));
        plan.push_back(bins_row(24'hFFFFFF, 12, 1'b1, 32'd2000));
        plan.push_back(reg_row(CFG_FIRST_BIN, 42'd511));
        plan.push_back(reg_row(CFG_END_BIN, 42'd0));
        plan.push_back(bins_row(24'hFFFFFF, 3, 1'b1, 32'd3000));
        // Debounce across the timestamp wrap
        plan.push_back(reg_row(CFG_FIRST_BIN, 42'd0));
        plan.push_back(reg_row(CFG_END_BIN, 42'd512));
        plan.push_back(reg_row(CFG_HOLDOFF, 42'd600));
        plan.push_back(reg_row(CFG_RATIO, 42'd0));
        plan.push_back(bins_row(24'hFFFFFF, 4, 1'b1, 32'hFFFF_FF00));
        plan.push_back(bins_row(24'hFFFFFF, 4, 1'b1, 32'h0000_0157));
        plan.push_back(bins_row(24'hFFFFFF, 4, 1'b1, 32'h0000_0158));
        // Energy exactly at the floor, then just above it
        plan.push_back(reg_row(CFG_HOLDOFF, 42'd0));
        plan.push_back(reg_row(CFG_ABS_THR, 42'd0));
        plan.push_back(bins_row(24'h004000, 10, 1'b1, 32'd5000));
        plan.push_back(bins_row(24'h004000, 11, 1'b1, 32'd5001));
        // Energy window at its extremes
        plan.push_back(reg_row(CFG_MIN_ENERGY, E_MAX));
        plan.push_back(bins_row(24'hFFFFFF, 2, 1'b1, 32'd6000));
        plan.push_back(bins_row(24'hFFFFFF, 70, 1'b1, 32'd6001));
        plan.push_back(reg_row(CFG_MIN_ENERGY, 42'd0));
        plan.push_back(reg_row(CFG_MAX_ENERGY, 42'd0));
        plan.push_back(bins_row(24'hFFFFFF, 2, 1'b1, 32'd6002));
        plan.push_back(reg_row(CFG_MAX_ENERGY, E_MAX));
        plan.push_back(reg_row(CFG_RATIO, 42'hFFFF));
        plan.push_back(reg_row(CFG_ABS_THR, E_MAX));
        plan.push_back(bins_row(24'h000100, 5, 1'b1, 32'd7000));
        plan.push_back(bins_row(24'hFFFFFF, 5, 1'b1, 32'd7001));

        // Hold reset, then release it at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Walk the directed plan
        prev_bins = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (prev_bins) settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                prev_bins = 1'b0;
            end else begin
                for (int k = 0; k < plan[i].count; k++) begin
                    lst = plan[i].last && (k == plan[i].count - 1);
                    send_bin(plan[i].mag, lst, lst ? plan[i].now : TS_W'($urandom),
                             lst && plan[i].typed, plan[i].want);
                end
                prev_bins = 1'b1;
            end
        end

        // Random phases: fresh settings, then a burst of frames
        rand_bins = 0;
        phase = 0;
        now = $urandom;
        while (rand_bins < RAND_BINS || phase < 2) begin
            settle();
            write_reg(CFG_ENABLE, E_W'($urandom_range(0, 7) != 0));
            case ($urandom_range(0, 3))
                0:       val = '0;
                1:       val = E_W'(16'hFFFF);
                2:       val = E_W'($urandom_range(256, 1024));
                default: val = E_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_reg(CFG_RATIO, val);
            case ($urandom_range(0, 3))
                0:       val = E_MAX;
                1:       val = rand_energy();
                2:       val = '0;
                default: val = rand_energy() >> $urandom_range(4, 16);
            endcase
            write_reg(CFG_ABS_THR, val);
            case ($urandom_range(0, 5))
                0:       val = rand_energy() >> $urandom_range(0, 20);
                1:       val = E_MAX;
                default: val = '0;
            endcase
            write_reg(CFG_MIN_ENERGY, val);
            case ($urandom_range(0, 5))
                0:       val = rand_energy();
                1:       val = '0;
                default: val = E_MAX;
            endcase
            write_reg(CFG_MAX_ENERGY, val);
            case ($urandom_range(0, 5))
                0:       val = E_W'(511);
                1:       val = E_W'($urandom_range(0, 511));
                default: val = E_W'($urandom_range(0, 8));
            endcase
            write_reg(CFG_FIRST_BIN, val);
            case ($urandom_range(0, 5))
                0:       val = '0;
                1:       val = E_W'(512);
                2:       val = E_W'($urandom_range(0, 512));
                default: val = E_W'($urandom_range(4, 40));
            endcase
            write_reg(CFG_END_BIN, val);
            case ($urandom_range(0, 4))
                0:       val = '0;
                1:       val = E_W'(16'hFFFF);
                default: val = E_W'($urandom_range(0, 800));
            endcase
            write_reg(CFG_HOLDOFF, val);

            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            nframes = $urandom_range(4, 12);

            // Back-pressure phase: sink holds off while short frames keep coming
            if (phase == 1) begin
                src_idle = 1'b0;
                hold_req = 1'b1;
                nframes = 40;
            end

            for (int f = 0; f < nframes; f++) begin
                if (phase == 1)
                    len = $urandom_range(1, 2);
                else if ($urandom_range(0, 99) == 0)
                    len = $urandom_range(500, 560);
                else
                    len = $urandom_range(1, 24);
                style = $urandom_range(0, 3);
                if ($urandom_range(0, 15) == 0)
                    now = $urandom;
                else
                    now = now + TS_W'($urandom_range(0, 900));
                for (int k = 0; k < len; k++) begin
                    lst = (k == len - 1);
                    send_bin(rand_mag(style), lst, lst ? now : TS_W'($urandom),
                             1'b0, '0);
                end
                rand_bins += len;
            end
            phase++;
        end

        // Drain and let the pipeline go quiet
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("band_energy_median_trigger_unit_tb: PASS");
        end else begin
            $display("band_energy_median_trigger_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
